### rtl/dfr_pkg.sv
// Shared types and constants for the dual fan relay and PWM sequencer.
`default_nettype none

package dfr_pkg;

    localparam int CMD_W = 7;

    localparam logic [CMD_W-1:0] DUTY_MAX      = 7'd100;
    localparam logic [CMD_W-1:0] SPEED_LEVEL   = 7'd30;
    localparam logic [CMD_W-1:0] TACHO_LEVEL   = 7'd10;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_HAS_TACHO    = 1'b0,
        REG_FILLBOX_MODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic has_tacho;
        logic fillbox_mode;
    } cfg_t;

    // One control tick after saturation, as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0] fan1_cmd;
        logic [CMD_W-1:0] fan2_cmd;
        logic             tach1_timed_out;
        logic             tach2_timed_out;
    } tick_t;

    typedef struct packed {
        logic [CMD_W-1:0] fan1_pwm;
        logic [CMD_W-1:0] fan2_pwm;
        logic             fan1_relay;
        logic             fan2_relay;
        logic             speed_over_30;
        logic             tacho_fault;
        logic             tach1_reload;
        logic             tach2_reload;
    } result_t;

    function automatic logic [CMD_W-1:0] sat_cmd(input logic [CMD_W-1:0] cmd);
        sat_cmd = (cmd > DUTY_MAX) ? DUTY_MAX : cmd;
    endfunction

endpackage

`default_nettype wire

### rtl/dfr_if.sv
// Valid/ready channel interfaces for control ticks and results.
`default_nettype none

interface dfr_in_if
    import dfr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] fan1_cmd;
    logic [CMD_W-1:0] fan2_cmd;
    logic             tach1_timed_out;
    logic             tach2_timed_out;

    modport source (output valid, fan1_cmd, fan2_cmd, tach1_timed_out, tach2_timed_out,
                    input ready);
    modport sink   (input valid, fan1_cmd, fan2_cmd, tach1_timed_out, tach2_timed_out,
                    output ready);
endinterface

interface dfr_out_if
    import dfr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] fan1_pwm;
    logic [CMD_W-1:0] fan2_pwm;
    logic             fan1_relay;
    logic             fan2_relay;
    logic             speed_over_30;
    logic             tacho_fault;
    logic             tach1_reload;
    logic             tach2_reload;

    modport source (output valid, fan1_pwm, fan2_pwm, fan1_relay, fan2_relay,
                    speed_over_30, tacho_fault, tach1_reload, tach2_reload,
                    input ready);
    modport sink   (input valid, fan1_pwm, fan2_pwm, fan1_relay, fan2_relay,
                    speed_over_30, tacho_fault, tach1_reload, tach2_reload,
                    output ready);
endinterface

`default_nettype wire

### rtl/dfr_regs.sv
// APB configuration registers: tacho presence and fillbox mode.
`default_nettype none

module dfr_regs
    import dfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_HAS_TACHO:    cfg_next.has_tacho    = pwdata[0];
                REG_FILLBOX_MODE: cfg_next.fillbox_mode = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.has_tacho    <= 1'b1;
            cfg_reg.fillbox_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_HAS_TACHO:    prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.has_tacho};
            REG_FILLBOX_MODE: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.fillbox_mode};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/dfr_channel.sv
// One fan channel: ramp counter, relay latch and PWM gating.
`default_nettype none

module dfr_channel
    import dfr_pkg::*;
#(
    parameter int DELAY = 20
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [CMD_W-1:0] cmd,
    output logic      [CMD_W-1:0] pwm,
    output logic                  relay
);

    localparam int CNT_W = $clog2(2 * DELAY + 1);
    localparam logic [CNT_W-1:0] DELAY_C = CNT_W'(DELAY);
    localparam logic [CNT_W-1:0] TOP_C   = CNT_W'(2 * DELAY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             relay_reg;
    logic             relay_next;

    always_comb
    begin
        count_next = count_reg;
        relay_next = relay_reg;
        pwm        = '0;
        if (cmd != '0)
        begin
            if (count_reg > DELAY_C)
                relay_next = 1'b1;
            if (count_reg < TOP_C)
                count_next = count_reg + 1'b1;
            else
                pwm = cmd;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            // new count below delay, i.e. old count at or below it
            if (count_reg <= DELAY_C)
                relay_next = 1'b0;
        end
        else
        begin
            relay_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            relay_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            relay_reg <= relay_next;
        end
    end

    assign relay = relay_next;

endmodule

`default_nettype wire

### rtl/dual_fan_relay_pwm_sequencer.sv
// Top level of the dual fan relay and PWM sequencer.
//
// Each transfer on in_ch is one control tick; it produces exactly one result transfer on out_ch.
// A tick is captured in an input register, then the ramp counters, relay latches and flags
// are evaluated combinationally into the result register, and a new tick is accepted every
// cycle while out_ch keeps up. The result stage stalls when out_ch is held; the input stage
// then takes a tick only while it is empty. Commands above 100 saturate to 100. RELAY_DELAY_TICKS
// sets the relay delay; each ramp counter runs from 0 to twice that value. Configuration
// (has_tacho at 0x0, fillbox_mode at 0x4) should be written only while no tick is in flight.
`default_nettype none

module dual_fan_relay_pwm_sequencer
    import dfr_pkg::*;
#(
    parameter int RELAY_DELAY_TICKS = 20
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    dfr_in_if.sink                  in_ch,
    dfr_out_if.source               out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;
    logic    fan1_relay;
    logic    fan2_relay;
    logic [CMD_W-1:0] fan1_pwm;
    logic [CMD_W-1:0] fan2_pwm;

    dfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Tick moves into the result register when there is room
    assign advance     = tick_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !tick_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (in_ch.ready)
            tick_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            tick_reg.fan1_cmd        <= sat_cmd(in_ch.fan1_cmd);
            tick_reg.fan2_cmd        <= sat_cmd(in_ch.fan2_cmd);
            tick_reg.tach1_timed_out <= in_ch.tach1_timed_out;
            tick_reg.tach2_timed_out <= in_ch.tach2_timed_out;
        end
    end

    dfr_channel #(.DELAY(RELAY_DELAY_TICKS)) u_fan1 (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (tick_reg.fan1_cmd),
        .pwm   (fan1_pwm),
        .relay (fan1_relay)
    );

    dfr_channel #(.DELAY(RELAY_DELAY_TICKS)) u_fan2 (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (tick_reg.fan2_cmd),
        .pwm   (fan2_pwm),
        .relay (fan2_relay)
    );

    always_comb
    begin
        logic fan1_run;
        logic fan2_run;
        logic fan2_checked;
        fan1_run     = tick_reg.fan1_cmd >= TACHO_LEVEL;
        fan2_run     = tick_reg.fan2_cmd >= TACHO_LEVEL;
        fan2_checked = cfg.has_tacho && !cfg.fillbox_mode;

        res_next.fan1_pwm      = fan1_pwm;
        res_next.fan2_pwm      = fan2_pwm;
        res_next.fan1_relay    = fan1_relay;
        res_next.fan2_relay    = fan2_relay;
        res_next.speed_over_30 = (tick_reg.fan1_cmd >= SPEED_LEVEL) ||
                                 (tick_reg.fan2_cmd >= SPEED_LEVEL);
        res_next.tacho_fault   = (cfg.has_tacho && fan1_run && tick_reg.tach1_timed_out) ||
                                 (fan2_checked && fan2_run && tick_reg.tach2_timed_out);
        res_next.tach1_reload  = cfg.has_tacho && !fan1_run;
        res_next.tach2_reload  = fan2_checked && !fan2_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (!res_valid_reg || out_ch.ready)
            res_valid_reg <= tick_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid         = res_valid_reg;
    assign out_ch.fan1_pwm      = res_reg.fan1_pwm;
    assign out_ch.fan2_pwm      = res_reg.fan2_pwm;
    assign out_ch.fan1_relay    = res_reg.fan1_relay;
    assign out_ch.fan2_relay    = res_reg.fan2_relay;
    assign out_ch.speed_over_30 = res_reg.speed_over_30;
    assign out_ch.tacho_fault   = res_reg.tacho_fault;
    assign out_ch.tach1_reload  = res_reg.tach1_reload;
    assign out_ch.tach2_reload  = res_reg.tach2_reload;

endmodule

`default_nettype wire
